// ===== hdl/rgb_to_hsv_converter_defines.svh =====
// Assertion helpers for the RGB to HSV converter.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Property that must hold at every edge.
`define RHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rgb2hsv_pkg.sv =====
`default_nettype none
package rgb2hsv_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS_DEF     = 16;
  // saturation is scaled by 2^SAT_BITS - 1
  localparam int SAT_BITS         = 16;
  localparam int QUEUE_DEPTH      = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// An accepted item passes the front register, the queue and then the divider stages in turn.
// Throughput: one item per clock while out_stall is low; the divider pipeline advances
// whenever its last stage is free. The four-entry queue between classifier and dividers
// absorbs output stall back-pressure. Reset: synchronous, active-low rst_n clears all valid
// bits, queue pointers and the count; data registers are not reset.
`default_nettype none
`include "rgb_to_hsv_converter_defines.svh"
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = rgb2hsv_pkg::HUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [CHANNEL_BITS-1:0]     in_red,
  input  wire logic [CHANNEL_BITS-1:0]     in_green,
  input  wire logic [CHANNEL_BITS-1:0]     in_blue,
  input  wire logic [CHANNEL_BITS-1:0]     in_alpha,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [HUE_BITS-1:0]              out_hue,
  output logic [rgb2hsv_pkg::SAT_BITS-1:0] out_saturation,
  output logic [CHANNEL_BITS-1:0]          out_brightness,
  output logic [CHANNEL_BITS-1:0]          out_alpha_out
);
  import rgb2hsv_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int HW = CHANNEL_BITS + 3;
  localparam int DW = CHANNEL_BITS + SAT_BITS;
  // queue entry: hue numerator, hue divisor, sat dividend, sat divisor, max, alpha
  localparam int QW = 2 * HW + DW + 3 * CB;

  q_stat_t       q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wr, q_rd;

  // front classifier outputs
  logic [HW-1:0] fe_hue_num, fe_hue_div;
  logic [DW-1:0] fe_sat_dvd;
  logic [CB-1:0] fe_sat_div, fe_bright, fe_alpha;

  // back divider inputs
  logic [HW-1:0] be_hue_num, be_hue_div;
  logic [DW-1:0] be_sat_dvd;
  logic [CB-1:0] be_sat_div, be_bright, be_alpha;

  // Front: max/min, sector, hue and saturation dividends and divisors; one register stage.
  rgb2hsv_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .q_stat   (q_stat),
    .push     (q_push),
    .hue_num  (fe_hue_num),
    .hue_div  (fe_hue_div),
    .sat_dvd  (fe_sat_dvd),
    .sat_div  (fe_sat_div),
    .bright   (fe_bright),
    .alpha    (fe_alpha)
  );

  assign q_wr = {fe_hue_num, fe_hue_div, fe_sat_dvd, fe_sat_div, fe_bright, fe_alpha};

  // Short queue decoupling the classifier from the divider pipeline.
  rgb2hsv_queue #(
    .W(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  assign {be_hue_num, be_hue_div, be_sat_dvd, be_sat_div, be_bright, be_alpha} = q_rd;

  // Back: two bit-per-stage restoring dividers running side by side;
  // the last stage is the output register.
  rgb2hsv_back #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .HUE_BITS    (HUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .hue_num        (be_hue_num),
    .hue_div        (be_hue_div),
    .sat_dvd        (be_sat_dvd),
    .sat_div        (be_sat_div),
    .bright         (be_bright),
    .alpha          (be_alpha),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha_out  (out_alpha_out)
  );

  // The queue status flags are exclusive.
  `RHC_ASSERT_ALWAYS(a_q_flags, !(q_stat.full && q_stat.empty), "queue full and empty")
  // Items are never popped from an empty queue.
  `RHC_ASSERT_ALWAYS(a_pop_nonempty, !q_pop || !q_stat.empty, "pop of empty queue")
  // An accepted item is held by the front stage on the next cycle.
  `RHC_ASSERT_NEXT(a_front_load, in_valid && !in_stall, q_push || in_stall, "front lost item")

endmodule
`default_nettype wire

// ===== hdl/rgb2hsv_front.sv =====
`default_nettype none
module rgb2hsv_front #(
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CHANNEL_BITS-1:0]  in_red,
  input  wire logic [CHANNEL_BITS-1:0]  in_green,
  input  wire logic [CHANNEL_BITS-1:0]  in_blue,
  input  wire logic [CHANNEL_BITS-1:0]  in_alpha,
  input  wire rgb2hsv_pkg::q_stat_t     q_stat,
  output logic                          push,
  output logic [CHANNEL_BITS+2:0]       hue_num,
  output logic [CHANNEL_BITS+2:0]       hue_div,
  output logic [CHANNEL_BITS+rgb2hsv_pkg::SAT_BITS-1:0] sat_dvd,
  output logic [CHANNEL_BITS-1:0]       sat_div,
  output logic [CHANNEL_BITS-1:0]       bright,
  output logic [CHANNEL_BITS-1:0]       alpha
);
  import rgb2hsv_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int HW = CHANNEL_BITS + 3;
  localparam int DW = CHANNEL_BITS + SAT_BITS;

  logic          valid_r, valid_nxt;
  logic          accept;
  logic [HW-1:0] hue_num_r, hue_num_nxt;
  logic [HW-1:0] hue_div_r, hue_div_nxt;
  logic [DW-1:0] sat_dvd_r, sat_dvd_nxt;
  logic [CB-1:0] sat_div_r, sat_div_nxt;
  logic [CB-1:0] bright_r, bright_nxt;
  logic [CB-1:0] alpha_r;

  logic [CB-1:0] mx, mn, dl;
  logic [HW-1:0] r_w, g_w, b_w, d_w, d6;

  assign in_stall = valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = valid_r && !q_stat.full;

  // max, min and sector of the max channel, red first
  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    dl  = mx - mn;
    r_w = HW'(in_red);
    g_w = HW'(in_green);
    b_w = HW'(in_blue);
    d_w = HW'(dl);
    d6  = (d_w << 2) + (d_w << 1);

    if (in_red == mx) begin
      hue_num_nxt = (in_green >= in_blue) ? (g_w - b_w) : (d6 - b_w + g_w);
    end else if (in_green == mx) begin
      hue_num_nxt = (d_w << 1) + b_w - r_w;
    end else begin
      hue_num_nxt = (d_w << 2) + r_w - g_w;
    end

    // gray and black pixels divide zero by one for hue; black ones also for saturation
    hue_div_nxt = (dl == '0) ? HW'(1) : d6;
    sat_div_nxt = (mx == '0) ? CB'(1) : mx;
    sat_dvd_nxt = {dl, {SAT_BITS{1'b0}}} - DW'(dl);
    bright_nxt  = mx;

    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (push) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hue_num_r <= hue_num_nxt;
      hue_div_r <= hue_div_nxt;
      sat_dvd_r <= sat_dvd_nxt;
      sat_div_r <= sat_div_nxt;
      bright_r  <= bright_nxt;
      alpha_r   <= in_alpha;
    end
  end

  assign hue_num = hue_num_r;
  assign hue_div = hue_div_r;
  assign sat_dvd = sat_dvd_r;
  assign sat_div = sat_div_r;
  assign bright  = bright_r;
  assign alpha   = alpha_r;

endmodule
`default_nettype wire

// ===== hdl/rgb2hsv_queue.sv =====
`default_nettype none
module rgb2hsv_queue #(
  parameter int W = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [W-1:0]         wr_data,
  input  wire logic                 pop,
  output logic [W-1:0]              rd_data,
  output rgb2hsv_pkg::q_stat_t      stat
);
  import rgb2hsv_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rgb2hsv_back.sv =====
`default_nettype none
module rgb2hsv_back #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rgb2hsv_pkg::q_stat_t     q_stat,
  output logic                          pop,
  input  wire logic [CHANNEL_BITS+2:0]  hue_num,
  input  wire logic [CHANNEL_BITS+2:0]  hue_div,
  input  wire logic [CHANNEL_BITS+rgb2hsv_pkg::SAT_BITS-1:0] sat_dvd,
  input  wire logic [CHANNEL_BITS-1:0]  sat_div,
  input  wire logic [CHANNEL_BITS-1:0]  bright,
  input  wire logic [CHANNEL_BITS-1:0]  alpha,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [HUE_BITS-1:0]           out_hue,
  output logic [rgb2hsv_pkg::SAT_BITS-1:0] out_saturation,
  output logic [CHANNEL_BITS-1:0]       out_brightness,
  output logic [CHANNEL_BITS-1:0]       out_alpha_out
);
  import rgb2hsv_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int HW    = CHANNEL_BITS + 3;
  localparam int SB    = SAT_BITS;
  localparam int STEPS = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

  // one quotient bit of each divider per stage, up to that divider's width
  logic                v_r    [STEPS];
  logic [HW-1:0]       hrem_r [STEPS];
  logic [HW-1:0]       hdiv_r [STEPS];
  logic [HUE_BITS-1:0] hq_r   [STEPS];
  logic [CB-1:0]       srem_r [STEPS];
  logic [SB-1:0]       slo_r  [STEPS];
  logic [CB-1:0]       sdiv_r [STEPS];
  logic [SB-1:0]       sq_r   [STEPS];
  logic [CB-1:0]       brt_r  [STEPS];
  logic [CB-1:0]       alp_r  [STEPS];

  logic adv;

  assign adv = !v_r[STEPS-1] || !out_stall;
  assign pop = adv && !q_stat.empty;

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic                v_in;
    logic [HW-1:0]       hrem_in, hdiv_in;
    logic [HUE_BITS-1:0] hq_in;
    logic [CB-1:0]       srem_in, sdiv_in, brt_in, alp_in;
    logic [SB-1:0]       slo_in, sq_in;

    logic [HW:0]         ht;
    logic [CB:0]         st;
    logic                hge, sge;
    logic [HW-1:0]       hrem_nxt;
    logic [HUE_BITS-1:0] hq_nxt;
    logic [CB-1:0]       srem_nxt;
    logic [SB-1:0]       slo_nxt, sq_nxt;

    if (s == 0) begin : g_head
      always_comb begin
        v_in    = !q_stat.empty;
        hrem_in = hue_num;
        hdiv_in = hue_div;
        hq_in   = '0;
        srem_in = sat_dvd[CB+SB-1:SB];
        slo_in  = sat_dvd[SB-1:0];
        sdiv_in = sat_div;
        sq_in   = '0;
        brt_in  = bright;
        alp_in  = alpha;
      end
    end else begin : g_body
      always_comb begin
        v_in    = v_r[s-1];
        hrem_in = hrem_r[s-1];
        hdiv_in = hdiv_r[s-1];
        hq_in   = hq_r[s-1];
        srem_in = srem_r[s-1];
        slo_in  = slo_r[s-1];
        sdiv_in = sdiv_r[s-1];
        sq_in   = sq_r[s-1];
        brt_in  = brt_r[s-1];
        alp_in  = alp_r[s-1];
      end
    end

    // restoring division step; stages past a divider's width pass through
    always_comb begin
      ht  = {hrem_in, 1'b0};
      hge = (ht >= {1'b0, hdiv_in});
      st  = {srem_in, slo_in[SB-1]};
      sge = (st >= {1'b0, sdiv_in});
      if (s < HUE_BITS) begin
        hrem_nxt = hge ? HW'(ht - {1'b0, hdiv_in}) : HW'(ht);
        hq_nxt   = {hq_in[HUE_BITS-2:0], hge};
      end else begin
        hrem_nxt = hrem_in;
        hq_nxt   = hq_in;
      end
      if (s < SB) begin
        srem_nxt = sge ? CB'(st - {1'b0, sdiv_in}) : CB'(st);
        slo_nxt  = {slo_in[SB-2:0], 1'b0};
        sq_nxt   = {sq_in[SB-2:0], sge};
      end else begin
        srem_nxt = srem_in;
        slo_nxt  = slo_in;
        sq_nxt   = sq_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hrem_r[s] <= hrem_nxt;
        hdiv_r[s] <= hdiv_in;
        hq_r[s]   <= hq_nxt;
        srem_r[s] <= srem_nxt;
        slo_r[s]  <= slo_nxt;
        sdiv_r[s] <= sdiv_in;
        sq_r[s]   <= sq_nxt;
        brt_r[s]  <= brt_in;
        alp_r[s]  <= alp_in;
      end
    end
  end

  assign out_valid      = v_r[STEPS-1];
  assign out_hue        = hq_r[STEPS-1];
  assign out_saturation = sq_r[STEPS-1];
  assign out_brightness = brt_r[STEPS-1];
  assign out_alpha_out  = alp_r[STEPS-1];

endmodule
`default_nettype wire

// ===== verif/rgb_to_hsv_converter_checker.sv =====
`default_nettype none
module rgb_to_hsv_converter_checker #(
  parameter int CHANNEL_BITS = rgb2hsv_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = rgb2hsv_pkg::HUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [CHANNEL_BITS-1:0]     in_red,
  input  wire logic [CHANNEL_BITS-1:0]     in_green,
  input  wire logic [CHANNEL_BITS-1:0]     in_blue,
  input  wire logic [CHANNEL_BITS-1:0]     in_alpha,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [HUE_BITS-1:0]         out_hue,
  input  wire logic [rgb2hsv_pkg::SAT_BITS-1:0] out_saturation,
  input  wire logic [CHANNEL_BITS-1:0]     out_brightness,
  input  wire logic [CHANNEL_BITS-1:0]     out_alpha_out,
  output int                               mismatch_count,
  output int                               hsv_pending,
  output int                               hsv_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAT_BITS = rgb2hsv_pkg::SAT_BITS;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_BITS-1:0]     sat;
    logic [CHANNEL_BITS-1:0] bright;
    logic [CHANNEL_BITS-1:0] alpha;
  } hsv_pixel_t;

  hsv_pixel_t hsv_due[$];
  hsv_pixel_t want_px;
  hsv_pixel_t got_px;

  initial begin
    mismatch_count = 0;
    hsv_pending    = 0;
    hsv_checked    = 0;
  end

  // exact integer hexcone conversion
  function automatic hsv_pixel_t rgb_pixel_to_hsv(
    input logic [CHANNEL_BITS-1:0] r,
    input logic [CHANNEL_BITS-1:0] g,
    input logic [CHANNEL_BITS-1:0] b,
    input logic [CHANNEL_BITS-1:0] a
  );
    longint unsigned mx, mn, delta, num;
    hsv_pixel_t px;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta    = mx - mn;
    px.alpha = a;
    if (mx == 0) begin
      px.hue    = '0;
      px.sat    = '0;
      px.bright = '0;
      return px;
    end
    px.bright = CHANNEL_BITS'(mx);
    px.sat    = SAT_BITS'((((64'd1 << SAT_BITS) - 1) * delta) / mx);
    if (delta == 0) begin
      px.hue = '0;
    end else begin
      // max channel checked red, green, blue in that order
      if (r == mx) begin
        if (g >= b) num = g - b;
        else num = 6 * delta - (b - g);
      end else if (g == mx) begin
        num = 2 * delta + b - r;
      end else begin
        num = 4 * delta + r - g;
      end
      px.hue = HUE_BITS'((num << HUE_BITS) / (6 * delta));
    end
    return px;
  endfunction

  task automatic log_mismatch(input string why, input hsv_pixel_t want, input hsv_pixel_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] MISMATCH %s: expected h=%0h s=%0h v=%0h a=%0h, got h=%0h s=%0h v=%0h a=%0h",
               $realtime, why, want.hue, want.sat, want.bright, want.alpha,
               got.hue, got.sat, got.bright, got.alpha);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        hsv_due.push_back(rgb_pixel_to_hsv(in_red, in_green, in_blue, in_alpha));
      if (out_valid && !out_stall) begin
        got_px = '{out_hue, out_saturation, out_brightness, out_alpha_out};
        hsv_checked++;
        if (hsv_due.size() == 0) begin
          log_mismatch("result with nothing outstanding", '0, got_px);
        end else begin
          want_px = hsv_due.pop_front();
          if (got_px.hue !== want_px.hue || got_px.sat !== want_px.sat ||
              got_px.bright !== want_px.bright || got_px.alpha !== want_px.alpha)
            log_mismatch("field", want_px, got_px);
        end
      end
      hsv_pending = hsv_due.size();
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_rgb_to_hsv_converter.sv =====
`default_nettype none
module tb_rgb_to_hsv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rgb2hsv_pkg::CHANNEL_BITS_DEF;
  localparam int HB = rgb2hsv_pkg::HUE_BITS_DEF;
  localparam int SB = rgb2hsv_pkg::SAT_BITS;
  localparam int RANDOM_PER_PHASE = 545;   // three phases, ~1635 random pixels
  localparam int DRAIN_CYCLES     = 40;    // outlasts the front, queue and divider stages by default

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CB-1:0] in_red = '0;
  logic [CB-1:0] in_green = '0;
  logic [CB-1:0] in_blue = '0;
  logic [CB-1:0] in_alpha = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [HB-1:0] out_hue;
  logic [SB-1:0] out_saturation;
  logic [CB-1:0] out_brightness;
  logic [CB-1:0] out_alpha_out;

  int mismatch_count;
  int hsv_pending;
  int hsv_checked;

  // percent chance per cycle that the sender holds off / the sink stalls
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int pixels_sent = 0;
  int directed_sent = 0;

  always #5 clk = ~clk;

  rgb_to_hsv_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness),
    .out_alpha_out (out_alpha_out)
  );

  // Scoreboard sits beside the DUT and watches both channels on its own.
  rgb_to_hsv_converter_checker #(.CHANNEL_BITS(CB), .HUE_BITS(HB)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness),
    .out_alpha_out (out_alpha_out),
    .mismatch_count(mismatch_count),
    .hsv_pending   (hsv_pending),
    .hsv_checked   (hsv_checked)
  );

  // Sink back-pressure, redrawn every falling edge from the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Idle gaps drop valid for whole cycles, so each edge sees one update only.
  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b, input logic [CB-1:0] a);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    // payload is held until an edge with stall low takes it
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Mix of shapes: plenty of full random pixels, plus gray, ties on the
  // max channel (red/green/blue priority), near-black and saturated ones.
  task automatic send_random_pixel();
    logic [CB-1:0] v, lo, r, g, b;
    v  = CB'($urandom);
    lo = CB'($urandom_range(v));
    r  = CB'($urandom);
    g  = CB'($urandom);
    b  = CB'($urandom);
    case ($urandom_range(9))
      0: begin
        r = v; g = v; b = v;                  // gray
      end
      1: begin
        case ($urandom_range(2))              // two channels tie at max
          0: begin r = v; g = v; b = lo; end
          1: begin r = v; g = lo; b = v; end
          default: begin r = lo; g = v; b = v; end
        endcase
      end
      2: begin
        r = CB'($urandom_range(3));           // near black
        g = CB'($urandom_range(3));
        b = CB'($urandom_range(3));
      end
      3: begin
        case ($urandom_range(2))              // one channel fully on
          0: r = '1;
          1: g = '1;
          default: b = '1;
        endcase
      end
      default: ;
    endcase
    send_pixel(r, g, b, CB'($urandom));
  endtask

  initial begin
    tx_idle_pct  = 36;
    rx_stall_pct = 68;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: black (both alpha extremes), gray, primaries,
    // ties between max channels, red sector wrapping below zero, tiny max.
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd170);
    send_pixel(8'd1,   8'd1,   8'd1,   8'd85);
    send_pixel(8'd255, 8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd1);
    send_pixel(8'd0,   8'd0,   8'd255, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd128);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd127);
    send_pixel(8'd255, 8'd0,   8'd255, 8'd64);
    send_pixel(8'd255, 8'd0,   8'd1,   8'd32);
    send_pixel(8'd255, 8'd1,   8'd0,   8'd16);
    send_pixel(8'd255, 8'd0,   8'd254, 8'd8);
    send_pixel(8'd1,   8'd0,   8'd0,   8'd4);
    send_pixel(8'd0,   8'd0,   8'd1,   8'd2);
    send_pixel(8'd1,   8'd0,   8'd1,   8'd200);
    send_pixel(8'd0,   8'd1,   8'd255, 8'd100);
    send_pixel(8'd254, 8'd255, 8'd0,   8'd50);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd25);
    send_pixel(8'd255, 8'd1,   8'd1,   8'd12);
    send_pixel(8'd170, 8'd85,  8'd85,  8'd240);
    directed_sent = pixels_sent;

    // Random part in three pressure phases: sender sparse/sink busy,
    // then swapped, then full rate on both sides.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 36; rx_stall_pct = 68; end
        1: begin tx_idle_pct = 68; rx_stall_pct = 36; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_pixel();
    end
    in_valid <= 1'b0;

    // drain: wait for every outstanding result, then watch for strays
    while (hsv_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d pixels (%0d directed corners, rest random over three back-pressure",
             pixels_sent, directed_sent);
    $display("phases); %0d results compared, %0d mismatches.", hsv_checked, mismatch_count);
    if (mismatch_count == 0 && hsv_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", hsv_pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
